// ===== rtl/qxmm_pkg.sv =====
package qxmm_pkg;

   localparam int Lanes     = 4;
   localparam int CmdW      = 16;
   localparam int MixW      = 15;
   localparam int PulseW    = 11;
   localparam int SumW      = CmdW + 2;
   localparam int ShW       = SumW + 1;
   localparam int ProdW     = ShW + MixW;
   localparam int PulseQW   = 10;
   localparam int PulseDivW = MixW + 1;
   localparam int PulseNumW = PulseDivW + PulseQW;

   localparam logic [MixW-1:0]      LimReset   = 15'd1000;
   localparam logic [PulseW-1:0]    PulseMin   = 11'd1000;
   localparam logic [PulseNumW-1:0] PulseScale = 26'd2000;

   typedef logic signed [CmdW-1:0] cmd_type;
   typedef logic signed [SumW-1:0] sum_type;
   typedef logic [ShW-1:0]         shifted_type;
   typedef logic [MixW-1:0]        mix_type;
   typedef logic [PulseW-1:0]      pulse_type;

   typedef struct packed {
      logic                          valid;
      mix_type                       lim;
      logic                          scale;
      shifted_type                   hi;
      shifted_type [Lanes-1:0]       m;
   } mix_out_type;

   typedef struct packed {
      logic                          valid;
      mix_type                       lim;
      mix_type [Lanes-1:0]           c;
   } scale_out_type;

   typedef struct packed {
      logic                          valid;
      mix_type [Lanes-1:0]           c;
      pulse_type [Lanes-1:0]         pulse;
   } pulse_out_type;

endpackage

// ===== rtl/qxmm_mix.sv =====
module qxmm_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  qxmm_pkg::cmd_type     throttle,
   input  qxmm_pkg::cmd_type     pitch,
   input  qxmm_pkg::cmd_type     roll,
   input  qxmm_pkg::cmd_type     yaw,
   input  qxmm_pkg::mix_type     lim,
   output qxmm_pkg::mix_out_type mix_out
);

   localparam int Lanes = qxmm_pkg::Lanes;
   localparam int SumW  = qxmm_pkg::SumW;
   localparam int ShW   = qxmm_pkg::ShW;
   localparam int MixW  = qxmm_pkg::MixW;

   // stage 1: raw mixes
   logic                  s1_valid_ff;
   qxmm_pkg::mix_type     s1_lim_ff;
   qxmm_pkg::sum_type     s1_m_ff [Lanes];
   qxmm_pkg::sum_type     t_x, p_x, r_x, y_x;

   assign t_x = SumW'(throttle);
   assign p_x = SumW'(pitch);
   assign r_x = SumW'(roll);
   assign y_x = SumW'(yaw);

   always_ff @(posedge clock) begin
      s1_valid_ff <= reset ? 1'b0 : in_valid;
      s1_lim_ff   <= lim;
      s1_m_ff[0]  <= t_x + p_x + r_x - y_x;
      s1_m_ff[1]  <= t_x + p_x - r_x + y_x;
      s1_m_ff[2]  <= t_x - p_x + r_x + y_x;
      s1_m_ff[3]  <= t_x - p_x - r_x - y_x;
   end

   // stage 2: lift so the smallest mix sits at zero if it is negative
   qxmm_pkg::sum_type     lo01, lo23, lo;
   logic signed [ShW-1:0] lift;
   logic                  s2_valid_ff;
   qxmm_pkg::mix_type     s2_lim_ff;
   qxmm_pkg::shifted_type s2_m_ff [Lanes];

   always_comb begin
      lo01 = (s1_m_ff[1] < s1_m_ff[0]) ? s1_m_ff[1] : s1_m_ff[0];
      lo23 = (s1_m_ff[3] < s1_m_ff[2]) ? s1_m_ff[3] : s1_m_ff[2];
      lo   = (lo23 < lo01) ? lo23 : lo01;
      lift = lo[SumW-1] ? ShW'(lo) : '0;
   end

   always_ff @(posedge clock) begin
      s2_valid_ff <= reset ? 1'b0 : s1_valid_ff;
      s2_lim_ff   <= s1_lim_ff;
      for (int i = 0; i < Lanes; i++) begin
         s2_m_ff[i] <= qxmm_pkg::shifted_type'(ShW'(s1_m_ff[i]) - lift);
      end
   end

   // stage 3: largest mix and scale decision
   qxmm_pkg::shifted_type hi01, hi23, hi;
   qxmm_pkg::mix_out_type mix_out_ff;

   always_comb begin
      hi01 = (s2_m_ff[1] > s2_m_ff[0]) ? s2_m_ff[1] : s2_m_ff[0];
      hi23 = (s2_m_ff[3] > s2_m_ff[2]) ? s2_m_ff[3] : s2_m_ff[2];
      hi   = (hi23 > hi01) ? hi23 : hi01;
   end

   always_ff @(posedge clock) begin
      mix_out_ff.valid <= reset ? 1'b0 : s2_valid_ff;
      mix_out_ff.lim   <= s2_lim_ff;
      mix_out_ff.hi    <= hi;
      mix_out_ff.scale <= hi > {{(ShW-MixW){1'b0}}, s2_lim_ff};
      for (int i = 0; i < Lanes; i++) begin
         mix_out_ff.m[i] <= s2_m_ff[i];
      end
   end

   assign mix_out = mix_out_ff;

endmodule

// ===== rtl/qxmm_scale.sv =====
module qxmm_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  qxmm_pkg::mix_out_type   mix_in,
   output qxmm_pkg::scale_out_type scale_out
);

   localparam int Lanes = qxmm_pkg::Lanes;
   localparam int MixW  = qxmm_pkg::MixW;
   localparam int ShW   = qxmm_pkg::ShW;
   localparam int ProdW = qxmm_pkg::ProdW;
   localparam int Steps = MixW;

   typedef struct packed {
      logic                  valid;
      qxmm_pkg::mix_type     lim;
      logic                  scale;
      qxmm_pkg::shifted_type hi;
   } side_type;

   side_type              side_ff [0:Steps];
   logic [ShW-1:0]        rem_ff  [0:Steps][Lanes];
   logic [MixW-1:0]       lq_ff   [0:Steps][Lanes];
   qxmm_pkg::mix_type     pass_ff [0:Steps][Lanes];
   logic [ProdW-1:0]      prod    [Lanes];

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         prod[i] = ProdW'(mix_in.m[i]) * ProdW'(mix_in.lim);
      end
   end

   // stage 0: m*lim, split into partial remainder and low bits
   always_ff @(posedge clock) begin
      side_ff[0] <= '{valid: mix_in.valid & ~reset, lim: mix_in.lim,
                      scale: mix_in.scale, hi: mix_in.hi};
      for (int i = 0; i < Lanes; i++) begin
         rem_ff[0][i]  <= prod[i][ProdW-1:MixW];
         lq_ff[0][i]   <= prod[i][MixW-1:0];
         pass_ff[0][i] <= mix_in.m[i][MixW-1:0];
      end
   end

   // one quotient bit per stage; low bits shift out as quotient bits shift in
   for (genvar s = 1; s <= Steps; s++) begin : g_step
      always_ff @(posedge clock) begin
         side_ff[s] <= '{valid: side_ff[s-1].valid & ~reset, lim: side_ff[s-1].lim,
                         scale: side_ff[s-1].scale, hi: side_ff[s-1].hi};
      end
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
         logic [ShW:0] t, diff;
         logic         ge;
         assign t    = {rem_ff[s-1][l], lq_ff[s-1][l][MixW-1]};
         assign diff = t - {1'b0, side_ff[s-1].hi};
         assign ge   = t >= {1'b0, side_ff[s-1].hi};
         always_ff @(posedge clock) begin
            rem_ff[s][l]  <= ge ? diff[ShW-1:0] : t[ShW-1:0];
            lq_ff[s][l]   <= {lq_ff[s-1][l][MixW-2:0], ge};
            pass_ff[s][l] <= pass_ff[s-1][l];
         end
      end
   end

   qxmm_pkg::scale_out_type out_ff;

   always_ff @(posedge clock) begin
      out_ff.valid <= reset ? 1'b0 : side_ff[Steps].valid;
      out_ff.lim   <= side_ff[Steps].lim;
      for (int i = 0; i < Lanes; i++) begin
         out_ff.c[i] <= side_ff[Steps].scale ? lq_ff[Steps][i] : pass_ff[Steps][i];
      end
   end

   assign scale_out = out_ff;

endmodule

// ===== rtl/qxmm_pulse.sv =====
module qxmm_pulse (
   input  logic                    clock,
   input  logic                    reset,
   input  qxmm_pkg::scale_out_type scale_in,
   output qxmm_pkg::pulse_out_type pulse_out
);

   localparam int Lanes = qxmm_pkg::Lanes;
   localparam int QW    = qxmm_pkg::PulseQW;
   localparam int DW    = qxmm_pkg::PulseDivW;
   localparam int NW    = qxmm_pkg::PulseNumW;
   localparam int PW    = qxmm_pkg::PulseW;
   localparam int Steps = QW;

   typedef struct packed {
      logic              valid;
      qxmm_pkg::mix_type lim;
      logic [DW-1:0]     d;
   } side_type;

   side_type          side_ff [0:Steps];
   logic [DW-1:0]     rem_ff  [0:Steps][Lanes];
   logic [QW-1:0]     lq_ff   [0:Steps][Lanes];
   qxmm_pkg::mix_type c_ff    [0:Steps][Lanes];
   logic [NW-1:0]     num     [Lanes];

   // round half up: (2000*c + lim) / (2*lim)
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         num[i] = NW'(scale_in.c[i]) * qxmm_pkg::PulseScale + NW'(scale_in.lim);
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{valid: scale_in.valid & ~reset, lim: scale_in.lim,
                      d: {scale_in.lim, 1'b0}};
      for (int i = 0; i < Lanes; i++) begin
         rem_ff[0][i] <= num[i][NW-1:QW];
         lq_ff[0][i]  <= num[i][QW-1:0];
         c_ff[0][i]   <= scale_in.c[i];
      end
   end

   for (genvar s = 1; s <= Steps; s++) begin : g_step
      always_ff @(posedge clock) begin
         side_ff[s] <= '{valid: side_ff[s-1].valid & ~reset, lim: side_ff[s-1].lim,
                         d: side_ff[s-1].d};
      end
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
         logic [DW:0] t, diff;
         logic        ge;
         assign t    = {rem_ff[s-1][l], lq_ff[s-1][l][QW-1]};
         assign diff = t - {1'b0, side_ff[s-1].d};
         assign ge   = t >= {1'b0, side_ff[s-1].d};
         always_ff @(posedge clock) begin
            rem_ff[s][l] <= ge ? diff[DW-1:0] : t[DW-1:0];
            lq_ff[s][l]  <= {lq_ff[s-1][l][QW-2:0], ge};
            c_ff[s][l]   <= c_ff[s-1][l];
         end
      end
   end

   qxmm_pkg::pulse_out_type out_ff;
   logic                    lim_zero;

   assign lim_zero = side_ff[Steps].lim == '0;

   // quotient never exceeds 1000, so the pulse tops out at 2000
   always_ff @(posedge clock) begin
      out_ff.valid <= reset ? 1'b0 : side_ff[Steps].valid;
      for (int i = 0; i < Lanes; i++) begin
         out_ff.c[i]     <= c_ff[Steps][i];
         out_ff.pulse[i] <= lim_zero ? qxmm_pkg::PulseMin
                                     : qxmm_pkg::PulseMin + PW'(lq_ff[Steps][i]);
      end
   end

   assign pulse_out = out_ff;

endmodule

// ===== rtl/quad_x_motor_mixer_pwm_unit.sv =====
// channel  | ports                              | handshake
// ---------+------------------------------------+----------------------------
// command  | req_throttle/pitch/roll/yaw_cmd    | start & !busy
// result   | rsp_mix_*, rsp_pulse_*             | rsp_valid, one-cycle strobe
// config   | csr_wr_en, csr_wr_data             | write on csr_wr_en
//
// A new command word can be taken every cycle outside reset; each result passes
// through 3 mix/desaturate stages, the product stage plus 15 one-bit-per-stage
// divide steps and a select stage for scaling, then one numerator stage, 10
// divide steps and the output register for the pulse.
// Synchronous reset clears only the stage valid bits and mix_limit (1000).
// busy is high only in reset; the receiver cannot stall, so nothing stalls.
module quad_x_motor_mixer_pwm_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  qxmm_pkg::cmd_type     req_throttle_cmd,
   input  qxmm_pkg::cmd_type     req_pitch_cmd,
   input  qxmm_pkg::cmd_type     req_roll_cmd,
   input  qxmm_pkg::cmd_type     req_yaw_cmd,
   input  logic                  csr_wr_en,
   input  qxmm_pkg::mix_type     csr_wr_data,
   output logic                  rsp_valid,
   output qxmm_pkg::mix_type     rsp_mix_front_left,
   output qxmm_pkg::mix_type     rsp_mix_front_right,
   output qxmm_pkg::mix_type     rsp_mix_back_left,
   output qxmm_pkg::mix_type     rsp_mix_back_right,
   output qxmm_pkg::pulse_type   rsp_pulse_front_left,
   output qxmm_pkg::pulse_type   rsp_pulse_front_right,
   output qxmm_pkg::pulse_type   rsp_pulse_back_left,
   output qxmm_pkg::pulse_type   rsp_pulse_back_right
);

   qxmm_pkg::mix_type       lim_ff;
   qxmm_pkg::mix_out_type   mix_out;
   qxmm_pkg::scale_out_type scale_out;
   qxmm_pkg::pulse_out_type pulse_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= qxmm_pkg::LimReset;
      end else if (csr_wr_en) begin
         lim_ff <= csr_wr_data;
      end
   end

   assign busy = reset;

   qxmm_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .throttle (req_throttle_cmd),
      .pitch    (req_pitch_cmd),
      .roll     (req_roll_cmd),
      .yaw      (req_yaw_cmd),
      .lim      (lim_ff),
      .mix_out  (mix_out)
   );

   qxmm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .mix_in    (mix_out),
      .scale_out (scale_out)
   );

   qxmm_pulse u_pulse (
      .clock     (clock),
      .reset     (reset),
      .scale_in  (scale_out),
      .pulse_out (pulse_out)
   );

   assign rsp_valid             = pulse_out.valid;
   assign rsp_mix_front_left    = pulse_out.c[0];
   assign rsp_mix_front_right   = pulse_out.c[1];
   assign rsp_mix_back_left     = pulse_out.c[2];
   assign rsp_mix_back_right    = pulse_out.c[3];
   assign rsp_pulse_front_left  = pulse_out.pulse[0];
   assign rsp_pulse_front_right = pulse_out.pulse[1];
   assign rsp_pulse_back_left   = pulse_out.pulse[2];
   assign rsp_pulse_back_right  = pulse_out.pulse[3];

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

   typedef struct {
      qxmm_pkg::cmd_type thr;
      qxmm_pkg::cmd_type pit;
      qxmm_pkg::cmd_type rol;
      qxmm_pkg::cmd_type yaw;
   } cmd_word_type;

   typedef struct {
      qxmm_pkg::mix_type   mix   [4];
      qxmm_pkg::pulse_type pulse [4];
   } motor_out_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   qxmm_pkg::cmd_type   req_throttle_cmd = '0;
   qxmm_pkg::cmd_type   req_pitch_cmd    = '0;
   qxmm_pkg::cmd_type   req_roll_cmd     = '0;
   qxmm_pkg::cmd_type   req_yaw_cmd      = '0;
   logic                csr_wr_en   = 1'b0;
   qxmm_pkg::mix_type   csr_wr_data = '0;
   logic                rsp_valid;
   qxmm_pkg::mix_type   rsp_mix_front_left, rsp_mix_front_right;
   qxmm_pkg::mix_type   rsp_mix_back_left, rsp_mix_back_right;
   qxmm_pkg::pulse_type rsp_pulse_front_left, rsp_pulse_front_right;
   qxmm_pkg::pulse_type rsp_pulse_back_left, rsp_pulse_back_right;

   cmd_word_type      pending_cmds[$];
   motor_out_type     expected_mixes[$];
   qxmm_pkg::mix_type cur_limit = qxmm_pkg::LimReset;
   int                err_count = 0;
   int                words_sent = 0;
   int                words_checked = 0;
   int                limits_used = 1;
   int                burst_left = 0;
   int                gap_left = 0;

   quad_x_motor_mixer_pwm_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_throttle_cmd      (req_throttle_cmd),
      .req_pitch_cmd         (req_pitch_cmd),
      .req_roll_cmd          (req_roll_cmd),
      .req_yaw_cmd           (req_yaw_cmd),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_mix_front_left    (rsp_mix_front_left),
      .rsp_mix_front_right   (rsp_mix_front_right),
      .rsp_mix_back_left     (rsp_mix_back_left),
      .rsp_mix_back_right    (rsp_mix_back_right),
      .rsp_pulse_front_left  (rsp_pulse_front_left),
      .rsp_pulse_front_right (rsp_pulse_front_right),
      .rsp_pulse_back_left   (rsp_pulse_back_left),
      .rsp_pulse_back_right  (rsp_pulse_back_right)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic motor_out_type mix_motors(cmd_word_type w, qxmm_pkg::mix_type limit);
      motor_out_type r;
      longint m [4];
      longint lo, hi, lim, c;
      lim = limit;
      m[0] = longint'(w.thr) + w.pit + w.rol - w.yaw;
      m[1] = longint'(w.thr) + w.pit - w.rol + w.yaw;
      m[2] = longint'(w.thr) - w.pit + w.rol + w.yaw;
      m[3] = longint'(w.thr) - w.pit - w.rol - w.yaw;
      lo = m[0];
      for (int i = 1; i < 4; i++) if (m[i] < lo) lo = m[i];
      // desaturate: if the lowest motor is negative, lift so it sits at zero
      if (lo < 0) for (int i = 0; i < 4; i++) m[i] -= lo;
      hi = m[0];
      for (int i = 1; i < 4; i++) if (m[i] > hi) hi = m[i];
      if (hi > lim) for (int i = 0; i < 4; i++) m[i] = (m[i] * lim) / hi;
      for (int i = 0; i < 4; i++) begin
         c = m[i];
         if (c < 0) c = 0;
         if (c > lim) c = lim;
         r.mix[i] = qxmm_pkg::mix_type'(c);
         if (lim <= 0) begin
            r.pulse[i] = qxmm_pkg::PulseMin;
         end else begin
            c = 1000 + (2000 * c + lim) / (2 * lim);
            if (c > 2000) c = 2000;
            r.pulse[i] = qxmm_pkg::pulse_type'(c);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_field(string what, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
   endtask

   function automatic qxmm_pkg::cmd_type rand_axis(int span);
      case ($urandom_range(0, 3))
         0: return qxmm_pkg::cmd_type'($urandom);
         1: return qxmm_pkg::cmd_type'($urandom_range(0, 2 * span) - span);
         2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return qxmm_pkg::cmd_type'($urandom_range(0, 15) - 8);
      endcase
   endfunction

   function automatic cmd_word_type make_word(qxmm_pkg::cmd_type t, qxmm_pkg::cmd_type p,
                                              qxmm_pkg::cmd_type r, qxmm_pkg::cmd_type y);
      cmd_word_type w;
      w.thr = t; w.pit = p; w.rol = r; w.yaw = y;
      return w;
   endfunction

   // driver: bursts of words separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_mixes.push_back(mix_motors(make_word(req_throttle_cmd, req_pitch_cmd,
                                                          req_roll_cmd, req_yaw_cmd),
                                                cur_limit));
            void'(pending_cmds.pop_front());
            words_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            start            <= 1'b1;
            req_throttle_cmd <= pending_cmds[0].thr;
            req_pitch_cmd    <= pending_cmds[0].pit;
            req_roll_cmd     <= pending_cmds[0].rol;
            req_yaw_cmd      <= pending_cmds[0].yaw;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      motor_out_type want;
      if (!reset && rsp_valid) begin
         if (expected_mixes.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            want = expected_mixes.pop_front();
            words_checked++;
            check_field("mix_front_left", rsp_mix_front_left, want.mix[0]);
            check_field("mix_front_right", rsp_mix_front_right, want.mix[1]);
            check_field("mix_back_left", rsp_mix_back_left, want.mix[2]);
            check_field("mix_back_right", rsp_mix_back_right, want.mix[3]);
            check_field("pulse_front_left", rsp_pulse_front_left, want.pulse[0]);
            check_field("pulse_front_right", rsp_pulse_front_right, want.pulse[1]);
            check_field("pulse_back_left", rsp_pulse_back_left, want.pulse[2]);
            check_field("pulse_back_right", rsp_pulse_back_right, want.pulse[3]);
         end
      end
   end

   task automatic drain;
      while (pending_cmds.size() != 0 || expected_mixes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(qxmm_pkg::mix_type v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_limit = v;
      limits_used++;
   endtask

   initial begin
      qxmm_pkg::mix_type limits [7];
      int                span;
      limits = '{15'd1, 15'd32767, 15'd0, 15'd3, 15'd1500, 15'd250, 15'd1000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset limit
      pending_cmds.push_back(make_word(0, 0, 0, 0));
      pending_cmds.push_back(make_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
      pending_cmds.push_back(make_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
      pending_cmds.push_back(make_word(16'sh7fff, 0, 0, 0));
      pending_cmds.push_back(make_word(16'sh8000, 0, 0, 0));
      pending_cmds.push_back(make_word(0, 16'sh7fff, 0, 0));
      pending_cmds.push_back(make_word(0, 0, 16'sh8000, 0));
      pending_cmds.push_back(make_word(0, 0, 0, 16'sh7fff));
      pending_cmds.push_back(make_word(500, 0, 0, 0));
      pending_cmds.push_back(make_word(400, 50, -30, 20));
      pending_cmds.push_back(make_word(-100, 20, 20, 20));
      pending_cmds.push_back(make_word(1000, 0, 0, 0));
      pending_cmds.push_back(make_word(1001, 1, 0, 0));
      pending_cmds.push_back(make_word(900, 200, 100, -50));
      pending_cmds.push_back(make_word(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
      pending_cmds.push_back(make_word(1, 0, 0, 0));
      pending_cmds.push_back(make_word(-1, -1, -1, -1));
      // sender holds off until every result is back
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) write_limit(limits[ph - 1]);
         span = (cur_limit == 0) ? 8 : cur_limit / 2 + 1;
         for (int k = 0; k < 125; k++)
            pending_cmds.push_back(make_word(rand_axis(span), rand_axis(span / 2),
                                             rand_axis(span / 2), rand_axis(span / 2)));
         drain();
      end
      write_limit(qxmm_pkg::mix_type'($urandom_range(1, 32767)));
      span = cur_limit / 2 + 1;
      for (int k = 0; k < 60; k++)
         pending_cmds.push_back(make_word(rand_axis(span), rand_axis(span / 2),
                                          rand_axis(span / 2), rand_axis(span / 2)));
      drain();
      repeat (40) @(posedge clock);

      if (expected_mixes.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_mixes.size()));
      end
      $display("Sent %0d command words, checked %0d results", words_sent, words_checked);
      $display("Covered %0d mix limit settings incl. zero, one and full scale", limits_used);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout waiting for results");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/qxmm_pkg.sv
rtl/qxmm_mix.sv
rtl/qxmm_scale.sv
rtl/qxmm_pulse.sv
rtl/quad_x_motor_mixer_pwm_unit.sv
verif/tb_top.sv
